@@ sv/pulse_charge_sequencer_top_assert.svh @@
// ----------------------------------------------------------------------------
// Pulse charge sequencer assertion macros
// Shorthand for the concurrent checks at the end of the sequencer top level.
// ----------------------------------------------------------------------------
`ifndef PULSE_CHARGE_SEQUENCER_TOP_ASSERT_SVH
`define PULSE_CHARGE_SEQUENCER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pulse charge sequencer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pulse charge sequencer: next-cycle check failed");

`endif

@@ sv/pcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Pulse charge sequencer package
// Field widths, command, status, mode and register codes shared by the block.
// ----------------------------------------------------------------------------
package pcs_pkg;

   localparam int MS_W      = 15;
   localparam int VOLT_W    = 16;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int PHASE_W   = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Discharge test: phases 0..LAST_SLICE are slices of period / 10.
   localparam logic [PHASE_W-1:0] LAST_SLICE = 4'd9;

   // Division by ten as a reciprocal multiply: x / 10 = (x * 52429) >> 19,
   // exact for every 15-bit x.
   localparam int              DIV10_SHIFT = 19;
   localparam int              DIV10_PROD_W = MS_W + 16;
   localparam logic [15:0]     DIV10_RECIP = 16'd52429;

   localparam logic [VOLT_W-1:0] CUTOFF_RESET = 16'd10500;

   // The last code is not a command; an item carrying it changes nothing.
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 2'd0,
      KIND_START  = 2'd1,
      KIND_STOP   = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GOOD         = 2'd0,
      STATUS_BUSY         = 2'd1,
      STATUS_UNCONFIGURED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MODE_DEFAULT   = 2'd0,
      MODE_ONE       = 2'd1,
      MODE_DISCHARGE = 2'd2,
      MODE_UNUSED    = 2'd3
   } mode_type;

   // The unused selection drives no pin, the same as none.
   typedef enum logic [1:0] {
      BAT_NONE   = 2'd0,
      BAT_ONE    = 2'd1,
      BAT_TWO    = 2'd2,
      BAT_UNUSED = 2'd3
   } battery_type;

   typedef enum logic [PHASE_W-1:0] {
      PHASE_CHARGE_ON     = 4'd0,
      PHASE_CHARGE_OFF    = 4'd1,
      PHASE_DISCHARGE_ON  = 4'd2,
      PHASE_DISCHARGE_OFF = 4'd3
   } charge_phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PERIOD         = 3'd0,
      REG_POSITIVE       = 3'd1,
      REG_NEGATIVE       = 3'd2,
      REG_NEED_DISCHARGE = 3'd3,
      REG_CHARGE_MODE    = 3'd4,
      REG_BATTERY_SELECT = 3'd5,
      REG_CUTOFF         = 3'd6
   } csr_index_type;

endpackage

@@ sv/pcs_req_if.sv @@
// ----------------------------------------------------------------------------
// Pulse charge sequencer request channel
// Valid/ready channel that carries one command item with battery readings.
// ----------------------------------------------------------------------------
interface pcs_req_if;

   logic                          valid;
   logic                          ready;
   logic [pcs_pkg::KIND_W-1:0]    kind;
   logic [pcs_pkg::VOLT_W-1:0]    volt_one_mv;
   logic [pcs_pkg::VOLT_W-1:0]    volt_two_mv;

   modport source (output valid, output kind, output volt_one_mv, output volt_two_mv,
                   input ready);
   modport sink   (input valid, input kind, input volt_one_mv, input volt_two_mv,
                   output ready);

endinterface

@@ sv/pcs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Pulse charge sequencer response channel
// Valid/ready channel that carries switch levels and status after each item.
// ----------------------------------------------------------------------------
interface pcs_rsp_if;

   logic                          valid;
   logic                          ready;
   logic                          charge_pin_one;
   logic                          charge_pin_two;
   logic                          discharge_pin_one;
   logic                          discharge_pin_two;
   logic                          running;
   logic [pcs_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output charge_pin_one, output charge_pin_two,
                   output discharge_pin_one, output discharge_pin_two,
                   output running, output status, input ready);
   modport sink   (input valid, input charge_pin_one, input charge_pin_two,
                   input discharge_pin_one, input discharge_pin_two,
                   input running, input status, output ready);

endinterface

@@ sv/pulse_charge_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// Pulse charge sequencer
// Millisecond tick sequencer that pulse-charges one of two batteries or runs a
// discharge test on one of them, with start, stop and tick command items.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Contents
//   req_bus   in         valid / ready    kind, volt_one_mv, volt_two_mv
//   rsp_bus   out        valid / ready    four switch levels, running, status
//   csr_*     in         write enable     register index, write data
//
// The sequencer state and the response of an item are written at the edge that
// accepts the item, so the response is on rsp_bus in the following cycle. A new
// item is taken in every cycle while the response is being taken. A stalled
// response holds the request side (req_bus.ready low) until it is taken.
// Reset (synchronous, active high) stops the sequence, clears all switches and
// loads the register reset values, with the cutoff at 10500 mV.
// ----------------------------------------------------------------------------

`include "pulse_charge_sequencer_top_assert.svh"

module pulse_charge_sequencer_top (
   input  logic                              clock,
   input  logic                              reset,
   pcs_req_if.sink                           req_bus,
   pcs_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [pcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcs_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [pcs_pkg::MS_W-1:0]    period_ms_ff;
   logic [pcs_pkg::MS_W-1:0]    positive_ms_ff;
   logic [pcs_pkg::MS_W-1:0]    negative_ms_ff;
   logic                        need_discharge_pulse_ff;
   logic [1:0]                  charge_mode_ff;
   logic [1:0]                  battery_select_ff;
   logic [pcs_pkg::VOLT_W-1:0]  cutoff_mv_ff;

   // Sequencer state and its next values.
   logic                         active_ff,           active_in;
   logic [pcs_pkg::PHASE_W-1:0]  phase_ff,            phase_in;
   logic [pcs_pkg::MS_W-1:0]     wait_count_ff,       wait_count_in;
   logic [1:0]                   charge_levels_ff,    charge_levels_in;
   logic [1:0]                   discharge_levels_ff, discharge_levels_in;
   logic [pcs_pkg::STATUS_W-1:0] status_ff,           status_in;
   logic                         rsp_valid_ff,        rsp_valid_in;

   logic                              req_accept;
   logic [1:0]                        sel_bits;
   logic [pcs_pkg::DIV10_PROD_W-1:0]  slice_prod;
   logic [pcs_pkg::MS_W-1:0]          slice_ms;
   logic [pcs_pkg::MS_W-1:0]          gap_positive_ms;
   logic [pcs_pkg::MS_W-1:0]          gap_negative_ms;
   logic                              below_cutoff;

   // The response register is freed by the consumer in the same cycle, so the
   // request side keeps flowing as long as responses are taken.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   // One-hot switch mask of the selected battery; no battery drives no pin.
   always_comb begin
      unique case (battery_select_ff)
         pcs_pkg::BAT_ONE: sel_bits = 2'b01;
         pcs_pkg::BAT_TWO: sel_bits = 2'b10;
         default:          sel_bits = 2'b00;
      endcase
   end

   // Slice length of the discharge test, period / 10 by reciprocal multiply.
   assign slice_prod = pcs_pkg::DIV10_PROD_W'(period_ms_ff)
                     * pcs_pkg::DIV10_PROD_W'(pcs_pkg::DIV10_RECIP);
   assign slice_ms   = pcs_pkg::MS_W'(slice_prod >> pcs_pkg::DIV10_SHIFT);

   // Off times after each pulse, saturated at zero.
   assign gap_positive_ms = (period_ms_ff > positive_ms_ff) ?
                            period_ms_ff - positive_ms_ff : '0;
   assign gap_negative_ms = (period_ms_ff > negative_ms_ff) ?
                            period_ms_ff - negative_ms_ff : '0;

   assign below_cutoff =
      (battery_select_ff == pcs_pkg::BAT_ONE && req_bus.volt_one_mv <= cutoff_mv_ff) ||
      (battery_select_ff == pcs_pkg::BAT_TWO && req_bus.volt_two_mv <= cutoff_mv_ff);

   // Next state for one item. A phase action runs on a tick of an active run when the
   // wait count has run down to zero; the count is then loaded with delay minus one (zero for a zero delay).
   always_comb begin
      logic [pcs_pkg::MS_W-1:0]    delay;
      logic [pcs_pkg::PHASE_W-1:0] eff_phase;

      delay               = '0;
      eff_phase           = phase_ff;
      active_in           = active_ff;
      phase_in            = phase_ff;
      wait_count_in       = wait_count_ff;
      charge_levels_in    = charge_levels_ff;
      discharge_levels_in = discharge_levels_ff;
      status_in           = pcs_pkg::STATUS_GOOD;

      unique case (req_bus.kind)
         pcs_pkg::KIND_TICK: begin
            if (active_ff && charge_mode_ff != pcs_pkg::MODE_UNUSED) begin
               if (wait_count_ff == '0) begin
                  if (charge_mode_ff == pcs_pkg::MODE_DISCHARGE) begin
                     // Even slices switch the discharge path on, odd slices off.
                     if (!phase_ff[0]) begin
                        discharge_levels_in = discharge_levels_ff | sel_bits;
                     end else begin
                        discharge_levels_in = discharge_levels_ff & ~sel_bits;
                     end
                     if (phase_ff < pcs_pkg::LAST_SLICE) begin
                        phase_in = phase_ff + 1'b1;
                        delay    = slice_ms;
                     end else begin
                        // End of the test cycle: a full period of rest, and the
                        // run ends once the battery is at or below the cutoff.
                        phase_in = '0;
                        delay    = period_ms_ff;
                        if (below_cutoff) begin
                           active_in = 1'b0;
                        end
                     end
                  end else begin
                     // Without a discharge pulse the cycle wraps after charging.
                     if (phase_ff == pcs_pkg::PHASE_DISCHARGE_ON && !need_discharge_pulse_ff) begin
                        eff_phase = pcs_pkg::PHASE_CHARGE_ON;
                     end
                     unique case (eff_phase)
                        pcs_pkg::PHASE_CHARGE_ON: begin
                           charge_levels_in = charge_levels_ff | sel_bits;
                           phase_in         = pcs_pkg::PHASE_CHARGE_OFF;
                           delay            = positive_ms_ff;
                        end
                        pcs_pkg::PHASE_CHARGE_OFF: begin
                           charge_levels_in = charge_levels_ff & ~sel_bits;
                           phase_in         = pcs_pkg::PHASE_DISCHARGE_ON;
                           delay            = gap_positive_ms;
                        end
                        pcs_pkg::PHASE_DISCHARGE_ON: begin
                           discharge_levels_in = discharge_levels_ff | sel_bits;
                           phase_in            = pcs_pkg::PHASE_DISCHARGE_OFF;
                           delay               = negative_ms_ff;
                        end
                        default: begin
                           // Discharge off, and any phase left over from the
                           // discharge test behaves the same way.
                           discharge_levels_in = discharge_levels_ff & ~sel_bits;
                           phase_in            = pcs_pkg::PHASE_CHARGE_ON;
                           delay               = gap_negative_ms;
                        end
                     endcase
                  end
                  wait_count_in = (delay == '0) ? '0 : delay - 1'b1;
               end else begin
                  wait_count_in = wait_count_ff - 1'b1;
               end
            end
         end
         pcs_pkg::KIND_START: begin
            if (active_ff) begin
               status_in = pcs_pkg::STATUS_BUSY;
            end else if (period_ms_ff == '0 || positive_ms_ff == '0 ||
                         negative_ms_ff == '0) begin
               status_in = pcs_pkg::STATUS_UNCONFIGURED;
            end else begin
               active_in     = 1'b1;
               wait_count_in = '0;
            end
         end
         pcs_pkg::KIND_STOP: begin
            active_in           = 1'b0;
            phase_in            = '0;
            wait_count_in       = '0;
            charge_levels_in    = '0;
            discharge_levels_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff           <= 1'b0;
         phase_ff            <= '0;
         wait_count_ff       <= '0;
         charge_levels_ff    <= '0;
         discharge_levels_ff <= '0;
         status_ff           <= pcs_pkg::STATUS_GOOD;
         rsp_valid_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            active_ff           <= active_in;
            phase_ff            <= phase_in;
            wait_count_ff       <= wait_count_in;
            charge_levels_ff    <= charge_levels_in;
            discharge_levels_ff <= discharge_levels_in;
            status_ff           <= status_in;
         end
      end
   end

   // Configuration writes; an index beyond the register list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ms_ff            <= '0;
         positive_ms_ff          <= '0;
         negative_ms_ff          <= '0;
         need_discharge_pulse_ff <= 1'b0;
         charge_mode_ff          <= pcs_pkg::MODE_DEFAULT;
         battery_select_ff       <= pcs_pkg::BAT_NONE;
         cutoff_mv_ff            <= pcs_pkg::CUTOFF_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pcs_pkg::REG_PERIOD:         period_ms_ff   <= csr_wdata[pcs_pkg::MS_W-1:0];
            pcs_pkg::REG_POSITIVE:       positive_ms_ff <= csr_wdata[pcs_pkg::MS_W-1:0];
            pcs_pkg::REG_NEGATIVE:       negative_ms_ff <= csr_wdata[pcs_pkg::MS_W-1:0];
            pcs_pkg::REG_NEED_DISCHARGE: need_discharge_pulse_ff <= csr_wdata[0];
            pcs_pkg::REG_CHARGE_MODE:    charge_mode_ff    <= csr_wdata[1:0];
            pcs_pkg::REG_BATTERY_SELECT: battery_select_ff <= csr_wdata[1:0];
            pcs_pkg::REG_CUTOFF:         cutoff_mv_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The response shows the state after the last accepted item.
   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.charge_pin_one    = charge_levels_ff[0];
   assign rsp_bus.charge_pin_two    = charge_levels_ff[1];
   assign rsp_bus.discharge_pin_one = discharge_levels_ff[0];
   assign rsp_bus.discharge_pin_two = discharge_levels_ff[1];
   assign rsp_bus.running           = active_ff;
   assign rsp_bus.status            = status_ff;

   // Every accepted item leaves a response behind.
   `PCS_ASSERT_NEXT(a_rsp_after_accept, req_accept, rsp_valid_ff)

   // A stop leaves the sequencer idle with every switch open.
   `PCS_ASSERT_NEXT(a_stop_clears,
      req_accept && req_bus.kind == pcs_pkg::KIND_STOP,
      !active_ff && charge_levels_ff == 2'b00 && discharge_levels_ff == 2'b00)

   // A start refused because the run is going does not disturb it.
   `PCS_ASSERT_NEXT(a_busy_start_keeps_run,
      req_accept && req_bus.kind == pcs_pkg::KIND_START && active_ff,
      active_ff && status_ff == pcs_pkg::STATUS_BUSY)

   // Between phase actions the wait count only counts down by one per tick.
   `PCS_ASSERT_NEXT(a_wait_counts_down,
      req_accept && req_bus.kind == pcs_pkg::KIND_TICK && active_ff &&
      charge_mode_ff != pcs_pkg::MODE_UNUSED && wait_count_ff != '0,
      wait_count_ff == $past(wait_count_ff) - 1'b1)

   // The phase never runs past the last discharge slice.
   `PCS_ASSERT_SAME(a_phase_in_range, 1'b1, phase_ff <= pcs_pkg::LAST_SLICE)

endmodule

@@ sim/pulse_charge_sequencer_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pulse charge sequencer testbench
// Drives tick, start and stop command items into the sequencer, programs its
// registers between phases, and checks every response item against a cycle-free
// model of the pulse and discharge-test sequencing kept in a small scoreboard.
// ----------------------------------------------------------------------------
module pulse_charge_sequencer_top_tb;

   // A run ends early when this many cycles pass with no item moving on
   // either channel. The longest correct pause is the receiver hold-off.
   localparam int IDLE_LIMIT      = 5000;
   localparam int LONG_HOLD       = 400;
   localparam int RANDOM_PHASES   = 16;
   localparam int QUIET_PHASES    = 3;
   localparam int ITEMS_PER_PHASE = 38;
   localparam int DRAIN_CYCLES    = 4;
   localparam int MAX_REPORTS     = 10;

   // Pin levels and status of one response item.
   typedef struct packed {
      logic                         charge_one;
      logic                         charge_two;
      logic                         discharge_one;
      logic                         discharge_two;
      logic                         running;
      logic [pcs_pkg::STATUS_W-1:0] status;
   } pin_state_type;

   typedef struct {
      logic [pcs_pkg::KIND_W-1:0] kind;
      logic [pcs_pkg::VOLT_W-1:0] volt_one;
      logic [pcs_pkg::VOLT_W-1:0] volt_two;
   } command_type;

   // The scoreboard keeps its own copy of the registers and the sequencer
   // state, predicts the pin levels after every accepted command item and
   // holds them until the matching response item arrives.
   class charge_scoreboard;
      logic [pcs_pkg::MS_W-1:0]    period_ms;
      logic [pcs_pkg::MS_W-1:0]    positive_ms;
      logic [pcs_pkg::MS_W-1:0]    negative_ms;
      logic                        need_discharge;
      pcs_pkg::mode_type           mode;
      logic [1:0]                  battery_sel;
      logic [pcs_pkg::VOLT_W-1:0]  cutoff_mv;

      logic                        active;
      logic [pcs_pkg::PHASE_W-1:0] phase;
      logic [pcs_pkg::MS_W-1:0]    wait_count;
      logic [1:0]                  charge_levels;
      logic [1:0]                  discharge_levels;

      pin_state_type               expected_pins[$];
      int                          mismatches;
      int                          responses;

      function new();
         period_ms        = '0;
         positive_ms      = '0;
         negative_ms      = '0;
         need_discharge   = 1'b0;
         mode             = pcs_pkg::MODE_DEFAULT;
         battery_sel      = pcs_pkg::BAT_NONE;
         cutoff_mv        = pcs_pkg::CUTOFF_RESET;
         active           = 1'b0;
         phase            = '0;
         wait_count       = '0;
         charge_levels    = '0;
         discharge_levels = '0;
         mismatches       = 0;
         responses        = 0;
      endfunction

      function int pending();
         return expected_pins.size();
      endfunction

      function void write_reg(pcs_pkg::csr_index_type index,
                              logic [pcs_pkg::CSR_DAT_W-1:0] data);
         case (index)
            pcs_pkg::REG_PERIOD:         period_ms      = data[pcs_pkg::MS_W-1:0];
            pcs_pkg::REG_POSITIVE:       positive_ms    = data[pcs_pkg::MS_W-1:0];
            pcs_pkg::REG_NEGATIVE:       negative_ms    = data[pcs_pkg::MS_W-1:0];
            pcs_pkg::REG_NEED_DISCHARGE: need_discharge = data[0];
            pcs_pkg::REG_CHARGE_MODE:    mode           = pcs_pkg::mode_type'(data[1:0]);
            pcs_pkg::REG_BATTERY_SELECT: battery_sel    = data[1:0];
            pcs_pkg::REG_CUTOFF:         cutoff_mv      = data[pcs_pkg::VOLT_W-1:0];
            default: ;
         endcase
      endfunction

      // Only battery one or battery two drives a pin.
      function logic [1:0] battery_mask();
         if (battery_sel == pcs_pkg::BAT_ONE) return 2'b01;
         if (battery_sel == pcs_pkg::BAT_TWO) return 2'b10;
         return 2'b00;
      endfunction

      function logic [pcs_pkg::MS_W-1:0] gap_after(logic [pcs_pkg::MS_W-1:0] width);
         return (period_ms > width) ? period_ms - width : '0;
      endfunction

      // One phase action; returns the delay in ticks until the next one.
      function logic [pcs_pkg::MS_W-1:0] advance_phase(
            logic [pcs_pkg::VOLT_W-1:0] volt_one,
            logic [pcs_pkg::VOLT_W-1:0] volt_two);
         logic [1:0] mask;
         mask = battery_mask();
         if (mode == pcs_pkg::MODE_DISCHARGE) begin
            if (phase[0] == 1'b0) discharge_levels = discharge_levels | mask;
            else discharge_levels = discharge_levels & ~mask;
            if (phase < pcs_pkg::LAST_SLICE) begin
               phase = phase + 1'b1;
               return period_ms / (pcs_pkg::MS_W'(pcs_pkg::LAST_SLICE) + 1'b1);
            end
            phase = '0;
            if ((battery_sel == pcs_pkg::BAT_ONE && volt_one <= cutoff_mv) ||
                (battery_sel == pcs_pkg::BAT_TWO && volt_two <= cutoff_mv)) active = 1'b0;
            return period_ms;
         end
         if (phase == pcs_pkg::PHASE_DISCHARGE_ON && !need_discharge)
            phase = pcs_pkg::PHASE_CHARGE_ON;
         case (phase)
            pcs_pkg::PHASE_CHARGE_ON: begin
               charge_levels = charge_levels | mask;
               phase = pcs_pkg::PHASE_CHARGE_OFF;
               return positive_ms;
            end
            pcs_pkg::PHASE_CHARGE_OFF: begin
               charge_levels = charge_levels & ~mask;
               phase = pcs_pkg::PHASE_DISCHARGE_ON;
               return gap_after(positive_ms);
            end
            pcs_pkg::PHASE_DISCHARGE_ON: begin
               discharge_levels = discharge_levels | mask;
               phase = pcs_pkg::PHASE_DISCHARGE_OFF;
               return negative_ms;
            end
            default: begin
               discharge_levels = discharge_levels & ~mask;
               phase = pcs_pkg::PHASE_CHARGE_ON;
               return gap_after(negative_ms);
            end
         endcase
      endfunction

      function void note_item(command_type cmd);
         logic [pcs_pkg::MS_W-1:0] delay;
         pcs_pkg::status_type      status;
         pin_state_type            pins;
         status = pcs_pkg::STATUS_GOOD;
         case (cmd.kind)
            pcs_pkg::KIND_TICK: begin
               if (active && mode != pcs_pkg::MODE_UNUSED) begin
                  if (wait_count == '0) begin
                     delay = advance_phase(cmd.volt_one, cmd.volt_two);
                     wait_count = (delay != '0) ? delay - 1'b1 : '0;
                  end else begin
                     wait_count = wait_count - 1'b1;
                  end
               end
            end
            pcs_pkg::KIND_START: begin
               if (active) begin
                  status = pcs_pkg::STATUS_BUSY;
               end else if (period_ms == '0 || positive_ms == '0 || negative_ms == '0) begin
                  status = pcs_pkg::STATUS_UNCONFIGURED;
               end else begin
                  active = 1'b1;
                  wait_count = '0;
               end
            end
            pcs_pkg::KIND_STOP: begin
               active           = 1'b0;
               phase            = '0;
               wait_count       = '0;
               charge_levels    = '0;
               discharge_levels = '0;
            end
            default: ;
         endcase
         pins.charge_one    = charge_levels[0];
         pins.charge_two    = charge_levels[1];
         pins.discharge_one = discharge_levels[0];
         pins.discharge_two = discharge_levels[1];
         pins.running       = active;
         pins.status        = status;
         expected_pins.push_back(pins);
      endfunction

      function void compare_field(string name, logic [1:0] want, logic [1:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: response %0d field %s expected %0d actual %0d",
                        responses, name, want, got);
         end
      endfunction

      function void check_result(pin_state_type got);
         pin_state_type want;
         if (expected_pins.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: response %0d arrived with no command item waiting",
                        responses);
         end else begin
            want = expected_pins.pop_front();
            compare_field("charge_pin_one",    want.charge_one,    got.charge_one);
            compare_field("charge_pin_two",    want.charge_two,    got.charge_two);
            compare_field("discharge_pin_one", want.discharge_one, got.discharge_one);
            compare_field("discharge_pin_two", want.discharge_two, got.discharge_two);
            compare_field("running",           want.running,       got.running);
            compare_field("status",            want.status,        got.status);
         end
         responses++;
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [pcs_pkg::CSR_IDX_W-1:0] csr_index;
   logic [pcs_pkg::CSR_DAT_W-1:0] csr_wdata;

   pcs_req_if req_bus ();
   pcs_rsp_if rsp_bus ();

   pulse_charge_sequencer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   charge_scoreboard sb = new();

   // Shared between the stimulus and the receiver: quiet turns off idling on
   // both sides, and a hold request makes the receiver stall for a long time.
   bit                         quiet;
   bit                         hold_request;
   logic [pcs_pkg::VOLT_W-1:0] cur_cutoff;
   command_type                commands[$];
   int                         idle_cycles = 0;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor. Both channels are sampled at the rising edge, before the
   // block's own updates of that edge land, so the order of processes within
   // a time step does not matter. The response for an item is registered and comes
   // after its command, so checking before noting at one edge is safe.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result('{charge_one:    rsp_bus.charge_pin_one,
                              charge_two:    rsp_bus.charge_pin_two,
                              discharge_one: rsp_bus.discharge_pin_one,
                              discharge_two: rsp_bus.discharge_pin_two,
                              running:       rsp_bus.running,
                              status:        rsp_bus.status});
         if (req_bus.valid && req_bus.ready)
            sb.note_item('{kind:     req_bus.kind,
                           volt_one: req_bus.volt_one_mv,
                           volt_two: req_bus.volt_two_mv});
      end
   end

   // Watchdog: counts cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver. It takes response items in random stretches, stalls in random bursts,
   // and on request holds off for a long time so that the block fills up and pushes
   // back on the command channel.
   initial begin
      logic lvl;
      int   hold;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            lvl  = 1'b0;
            hold = LONG_HOLD;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            lvl  = 1'b0;
            hold = $urandom_range(1, 9);
         end else begin
            lvl  = 1'b1;
            hold = $urandom_range(1, 12);
         end
         rsp_bus.ready <= lvl;
         repeat (hold) @(posedge clock);
      end
   end

   // Register write, one per cycle. The scoreboard copy is updated at the
   // same edge; no command item is in flight while registers are written.
   task automatic write_csr(pcs_pkg::csr_index_type index,
                            logic [pcs_pkg::CSR_DAT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(index, data);
   endtask

   // Random data above a register's width, so that every write data bit
   // toggles; the block has to ignore it.
   function automatic logic [pcs_pkg::CSR_DAT_W-1:0] junk_above(int width);
      logic [pcs_pkg::CSR_DAT_W-1:0] r;
      r = pcs_pkg::CSR_DAT_W'($urandom);
      if ($urandom_range(0, 3) != 0) r = '0;
      return (r >> width) << width;
   endfunction

   task automatic program_all(logic [pcs_pkg::MS_W-1:0] period,
                              logic [pcs_pkg::MS_W-1:0] pos_width,
                              logic [pcs_pkg::MS_W-1:0] neg_width, logic need_dis,
                              logic [1:0] mode, logic [1:0] battery,
                              logic [pcs_pkg::VOLT_W-1:0] cutoff);
      write_csr(pcs_pkg::REG_PERIOD,
                junk_above(pcs_pkg::MS_W) | pcs_pkg::CSR_DAT_W'(period));
      write_csr(pcs_pkg::REG_POSITIVE,
                junk_above(pcs_pkg::MS_W) | pcs_pkg::CSR_DAT_W'(pos_width));
      write_csr(pcs_pkg::REG_NEGATIVE,
                junk_above(pcs_pkg::MS_W) | pcs_pkg::CSR_DAT_W'(neg_width));
      write_csr(pcs_pkg::REG_NEED_DISCHARGE,
                junk_above(1) | pcs_pkg::CSR_DAT_W'(need_dis));
      write_csr(pcs_pkg::REG_CHARGE_MODE,
                junk_above(2) | pcs_pkg::CSR_DAT_W'(mode));
      write_csr(pcs_pkg::REG_BATTERY_SELECT,
                junk_above(2) | pcs_pkg::CSR_DAT_W'(battery));
      write_csr(pcs_pkg::REG_CUTOFF, cutoff);
      csr_we <= 1'b0;
      cur_cutoff = cutoff;
   endtask

   // Sends every queued command item. Valid stays high from one item to the
   // next unless the sender idles, and drops after the last one.
   task automatic send_commands();
      command_type cmd;
      while (commands.size() > 0) begin
         cmd = commands.pop_front();
         if (!quiet && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         req_bus.valid       <= 1'b1;
         req_bus.kind        <= cmd.kind;
         req_bus.volt_one_mv <= cmd.volt_one;
         req_bus.volt_two_mv <= cmd.volt_two;
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
      end
      req_bus.valid <= 1'b0;
   endtask

   // Waits until every response item has been checked, then lets the
   // block settle before registers are touched again. The last command
   // item is noted by the monitor at the edge that takes it, so drain waits
   // for the monitor to note it before the waiting count is trusted.
   task automatic drain();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void push_command(logic [pcs_pkg::KIND_W-1:0] kind,
                                        logic [pcs_pkg::VOLT_W-1:0] volt_one,
                                        logic [pcs_pkg::VOLT_W-1:0] volt_two);
      commands.push_back('{kind: kind, volt_one: volt_one, volt_two: volt_two});
   endfunction

   // Readings either anywhere in range, at the rails, or right around the
   // cutoff so that the discharge test stops itself now and then.
   function automatic logic [pcs_pkg::VOLT_W-1:0] pick_volt();
      int v;
      case ($urandom_range(0, 3))
         0: return pcs_pkg::VOLT_W'($urandom);
         1: return ($urandom_range(0, 1) != 0) ? '1 : '0;
         default: begin
            v = int'(cur_cutoff) + int'($urandom_range(0, 6)) - 3;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            return pcs_pkg::VOLT_W'(v);
         end
      endcase
   endfunction

   // A phase of random command items: mostly ticks, opened by a start about half
   // the time, with stray starts, stops and unused kinds mixed in.
   function automatic void queue_random_phase(int count);
      int                         r;
      logic [pcs_pkg::KIND_W-1:0] kind;
      if ($urandom_range(0, 1) != 0)
         push_command(pcs_pkg::KIND_START, pick_volt(), pick_volt());
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 80) kind = pcs_pkg::KIND_TICK;
         else if (r < 88) kind = pcs_pkg::KIND_START;
         else if (r < 95) kind = pcs_pkg::KIND_STOP;
         else kind = pcs_pkg::KIND_UNUSED;
         push_command(kind, pick_volt(), pick_volt());
      end
   endfunction

   initial begin
      quiet               = 1'b0;
      hold_request        = 1'b0;
      cur_cutoff          = pcs_pkg::CUTOFF_RESET;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= pcs_pkg::REG_PERIOD;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= pcs_pkg::KIND_TICK;
      req_bus.volt_one_mv <= '0;
      req_bus.volt_two_mv <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. With the reset registers a start is refused as not
      // configured; ticks, an unused kind and a stop change nothing.
      push_command(pcs_pkg::KIND_START,  '0, '1);
      push_command(pcs_pkg::KIND_TICK,   '1, '0);
      push_command(pcs_pkg::KIND_UNUSED, '1, '1);
      push_command(pcs_pkg::KIND_STOP,   '0, '0);
      send_commands();
      drain();

      // A zero discharge width alone is enough to refuse a start.
      program_all(15'd4, 15'd1, 15'd0, 1'b1, pcs_pkg::MODE_DEFAULT, pcs_pkg::BAT_ONE,
                  pcs_pkg::CUTOFF_RESET);
      push_command(pcs_pkg::KIND_START, '0, '0);
      send_commands();
      drain();

      // Charge pulse wider than the period: the off gap saturates at zero.
      // A second start while running is refused as busy.
      program_all(15'd4, 15'd6, 15'd2, 1'b1, pcs_pkg::MODE_DEFAULT, pcs_pkg::BAT_ONE,
                  pcs_pkg::CUTOFF_RESET);
      push_command(pcs_pkg::KIND_START, '0, '0);
      push_command(pcs_pkg::KIND_START, '0, '0);
      repeat (6) push_command(pcs_pkg::KIND_TICK, '1, '1);
      push_command(pcs_pkg::KIND_STOP, '0, '0);
      send_commands();
      drain();

      // Discharge test on battery two with a period under ten: every slice
      // has zero delay, and a low reading at the last slice ends the run.
      program_all(15'd5, 15'd1, 15'd1, 1'b0, pcs_pkg::MODE_DISCHARGE, pcs_pkg::BAT_TWO,
                  16'hFFFF);
      push_command(pcs_pkg::KIND_START, '0, '0);
      repeat (10) push_command(pcs_pkg::KIND_TICK, '1, '0);
      send_commands();
      drain();

      // Random part. The first few phases use fixed settings for the
      // register extremes and the unused mode; the sequencer is usually left
      // running across phases, so mode changes land on odd phase values. The
      // last phases run with no idling on either side.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         quiet = (p >= RANDOM_PHASES - QUIET_PHASES);
         case (p)
            0: program_all('1, '1, '1, 1'b1, pcs_pkg::MODE_ONE, pcs_pkg::BAT_UNUSED, '1);
            1: program_all(15'd1, 15'd1, 15'd1, 1'b1, pcs_pkg::MODE_DEFAULT,
                           pcs_pkg::BAT_TWO, '0);
            2: program_all(15'd12, 15'd3, 15'd2, 1'b0, pcs_pkg::MODE_DISCHARGE,
                           pcs_pkg::BAT_ONE, 16'd12000);
            3: program_all(15'd7, 15'd2, 15'd3, 1'b1, pcs_pkg::MODE_UNUSED,
                           pcs_pkg::BAT_ONE, pcs_pkg::CUTOFF_RESET);
            default:
               program_all(($urandom_range(0, 9) == 0) ?
                              pcs_pkg::MS_W'(0) : pcs_pkg::MS_W'($urandom_range(1, 24)),
                           pcs_pkg::MS_W'($urandom_range(0, 30)),
                           pcs_pkg::MS_W'($urandom_range(0, 30)),
                           1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                           2'($urandom_range(0, 3)), pcs_pkg::VOLT_W'($urandom));
         endcase
         // Long receiver stall while commands keep coming.
         if (p == 5) hold_request = 1'b1;
         queue_random_phase(ITEMS_PER_PHASE);
         send_commands();
         drain();
      end

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
